// ===== hw/rtl/stoc_pkg.sv =====
// ----------------------------------------------------------------------------
// stoc_pkg
// Shared types and constants for the sorted-table occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package stoc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 2;   // signed search bound, holds -1..depth
  localparam int CFG_W       = 11;           // entry_count register
  localparam int IDX_W       = 10;           // index field
  localparam int VAL_W       = 32;           // value field
  localparam int OCC_W       = 11;           // occurrences field
  localparam int POS_W       = 10;           // first_position field
  localparam int IN_DATA_W   = 48;           // index + value, padded to bytes
  localparam int OUT_DATA_W  = 24;           // occurrences + first_position, padded

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } stoc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } stoc_state_t;

  typedef struct packed {
    logic wr_en;     // store the accepted write item
    logic start;     // latch key, open the leftmost search
    logic restart;   // open the rightmost search
    logic rd_en;     // read the table at the midpoint
    logic cmp_en;    // compare and narrow the bounds
    logic load_out;  // load the result register
  } stoc_cmd_t;

  typedef struct packed {
    logic in_range;   // lo <= hi
    logic pass_last;  // rightmost search running
    logic out_busy;   // result register holds an untaken result
  } stoc_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// stoc_ctrl
// Sequencer for table writes and the two binary searches of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module stoc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_op,
  output logic                     in_tready,
  input  wire stoc_pkg::stoc_sts_t sts,
  output stoc_pkg::stoc_cmd_t      cmd
);
  import stoc_pkg::*;

  stoc_state_t state_r, state_nxt;
  logic        accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_QUERY)) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.in_range)       state_nxt = ST_CMP;
        else if (sts.pass_last) state_nxt = ST_DONE;
      end
      ST_CMP: begin
        state_nxt = ST_PROBE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_en = accept && (in_op == OP_WRITE);
        cmd.start = accept && (in_op == OP_QUERY);
      end
      ST_PROBE: begin
        cmd.rd_en   = sts.in_range;
        cmd.restart = !sts.in_range && !sts.pass_last;
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stoc_dpath.sv =====
// ----------------------------------------------------------------------------
// stoc_dpath
// Table memory, search bounds, hit tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stoc_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire stoc_pkg::stoc_cmd_t                 cmd,
  output stoc_pkg::stoc_sts_t                      sts,
  input  wire logic [stoc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                cfg_valid,
  input  wire logic [stoc_pkg::CFG_W-1:0]          cfg_data,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [stoc_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                     out_tuser
);
  import stoc_pkg::*;

  logic [VAL_W-1:0]        mem [TABLE_DEPTH];
  logic [VAL_W-1:0]        rd_data_r;
  logic [ADDR_W-1:0]       mid_r;
  logic [CFG_W-1:0]        entry_count_r;
  logic [VAL_W-1:0]        key_r;
  logic signed [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic                    pass_last_r;
  logic                    first_vld_r, last_vld_r;
  logic [ADDR_W-1:0]       first_r, last_r;
  logic                    out_vld_r;
  logic [OCC_W-1:0]        occ_r;
  logic [POS_W-1:0]        pos_r;
  logic                    found_r;

  logic [IDX_W-1:0]        in_index;
  logic [VAL_W-1:0]        in_value;
  logic [CFG_W-1:0]        n_clamp;
  logic signed [CNT_W-1:0] hi_init;
  logic [CNT_W:0]          mid_sum;
  logic [ADDR_W-1:0]       mid;
  logic signed [CNT_W-1:0] mid_inc, mid_dec;
  logic                    key_eq, key_lt;
  logic                    hit_ok;
  logic [ADDR_W:0]         span;

  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W+VAL_W-1:IDX_W];

  assign n_clamp = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ?
                   CFG_W'(TABLE_DEPTH) : entry_count_r;
  assign hi_init = $signed(CNT_W'(n_clamp)) - $signed(CNT_W'(1));

  // bounds are non-negative whenever a probe is issued
  assign mid_sum = {lo_r[CNT_W-1], lo_r} + {hi_r[CNT_W-1], hi_r};
  assign mid     = mid_sum[ADDR_W:1];
  assign mid_inc = $signed(CNT_W'({1'b0, mid_r})) + $signed(CNT_W'(1));
  assign mid_dec = $signed(CNT_W'({1'b0, mid_r})) - $signed(CNT_W'(1));

  assign key_eq = (rd_data_r == key_r);
  assign key_lt = ($signed(rd_data_r) < $signed(key_r));

  assign sts.in_range  = (lo_r <= hi_r);
  assign sts.pass_last = pass_last_r;
  assign sts.out_busy  = out_vld_r && !out_tready;

  // table port: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (32'(in_index) < 32'(TABLE_DEPTH))) begin
      mem[ADDR_W'(in_index)] <= in_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[mid];
      mid_r     <= mid;
    end
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.start || cmd.restart) begin
      lo_nxt = '0;
      hi_nxt = hi_init;
    end else if (cmd.cmp_en) begin
      if (key_eq) begin
        if (pass_last_r) lo_nxt = mid_inc;
        else             hi_nxt = mid_dec;
      end else if (key_lt) begin
        lo_nxt = mid_inc;
      end else begin
        hi_nxt = mid_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.start) key_r <= in_value;
    if (cmd.cmp_en && key_eq) begin
      if (pass_last_r) last_r  <= mid_r;
      else             first_r <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      pass_last_r   <= 1'b0;
      first_vld_r   <= 1'b0;
      last_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid) entry_count_r <= cfg_data;
      if (cmd.start) begin
        pass_last_r <= 1'b0;
        first_vld_r <= 1'b0;
        last_vld_r  <= 1'b0;
      end else begin
        if (cmd.restart) pass_last_r <= 1'b1;
        if (cmd.cmp_en && key_eq) begin
          if (pass_last_r) last_vld_r  <= 1'b1;
          else             first_vld_r <= 1'b1;
        end
      end
    end
  end

  // result
  assign hit_ok = first_vld_r && last_vld_r && (last_r >= first_r);
  assign span   = {1'b0, last_r} - {1'b0, first_r} + (ADDR_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      occ_r   <= hit_ok ? OCC_W'(span) : '0;
      pos_r   <= hit_ok ? POS_W'(first_r) : '0;
      found_r <= hit_ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W-OCC_W-POS_W)'(0), pos_r, occ_r};
  assign out_tuser  = found_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_occurrence_count_core.sv =====
// Write item: the table is updated at the edge that accepts it, and the block stays idle.
// Query: each probe reads the table at the midpoint, then compares and narrows the
// bounds; a search over n entries makes up to floor(log2 n)+1 probes, and a query runs
// a leftmost then a rightmost search. The single table read port serves one probe at a time.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the controller, the result valid flag and entry_count; the table is not cleared.
// ----------------------------------------------------------------------------
// sorted_table_occurrence_count_core
// Counts the entries of a sorted table equal to a key with a leftmost and a
// rightmost binary search, and reports the first matching position.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_occurrence_count_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [stoc_pkg::IN_DATA_W-1:0] in_tdata,   // [9:0] index, [41:10] value
  input  wire logic                           in_tuser,   // [0] op: 0 write, 1 query
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [stoc_pkg::OUT_DATA_W-1:0]     out_tdata,  // [10:0] occurrences,
                                                          // [20:11] first_position
  output logic                                out_tuser,  // [0] found
  // entry_count register write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stoc_pkg::CFG_W-1:0]     cfg_data
);
  import stoc_pkg::*;

  stoc_cmd_t cmd;
  stoc_sts_t sts;

  // register writes land at once; software must write only while idle (block does not check)
  assign cfg_ready = 1'b1;

  // controller: accepts items, steps the two searches, hands off the result
  stoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: table memory, bounds, hit capture and output register
  stoc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/stoc_checker.sv =====
// ----------------------------------------------------------------------------
// stoc_checker
// Port-level checks for the sorted-table occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

module stoc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [stoc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tuser
);
  import stoc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // found agrees with a nonzero count
  a_found_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[OCC_W-1:0] != '0)))
    else $error("found and occurrences disagree");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[OCC_W+POS_W-1:OCC_W] == '0))
    else $error("miss with nonzero first position");

  // a query transfer takes the input side busy for the search
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("input ready during search");

endmodule

bind sorted_table_occurrence_count_core stoc_checker u_stoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/sv/sorted_table_occurrence_count_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_occurrence_count_core_tb
// Self-checking bench for the occurrence counter. Table writes and key queries
// stream in with random gaps, and results are taken with a stalling receiver.
// A mirror of the table and of entry_count predicts each query's count, first
// position and found flag unless a directed row gives them. A short directed
// table comes first, then searches over the whole depth, then phases of random
// traffic, each over a freshly written sorted prefix.
// ----------------------------------------------------------------------------

module sorted_table_occurrence_count_core_tb;
  import stoc_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transfer
  localparam int ITEM_BUDGET    = 750;   // input items over the whole run
  localparam int NUM_DIRECTED   = 27;

  typedef struct packed {
    logic [OCC_W-1:0] occ;
    logic [POS_W-1:0] pos;
    logic             found;
  } count_result_t;

  // One row of the directed table: an item, or an entry_count write.
  typedef struct {
    bit               is_cfg;
    stoc_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    bit               typed;   // expected result given in the row
    count_result_t    fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [9:0] index, [41:10] value
  logic                  in_tuser = 1'b0; // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [10:0] occurrences, [20:11] first_position
  logic                  out_tuser;       // [0] found
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Mirror of the block's state as seen through accepted transfers.
  logic [VAL_W-1:0] table_mirror [TABLE_DEPTH];
  logic [CFG_W-1:0] entry_count_mirror = '0;
  count_result_t    pending_counts [$];

  int mismatch_count = 0;
  int write_count = 0;
  int query_count = 0;
  int hit_count = 0;
  int cfg_count = 0;
  int item_count = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  int ready_run = 0;
  logic ready_level = 1'b0;
  count_result_t got_result;
  stim_row_t directed_rows [NUM_DIRECTED];

  sorted_table_occurrence_count_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Leftmost or rightmost position of key over the first n mirror entries, -1 if none.
  function automatic int find_edge(int n, logic [VAL_W-1:0] key, bit want_last);
    int lo;
    int hi;
    int mid;
    int hit;
    lo = 0;
    hi = n - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_mirror[mid] == key) begin
        hit = mid;
        if (want_last) lo = mid + 1;
        else hi = mid - 1;
      end else if ($signed(table_mirror[mid]) < $signed(key)) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  function automatic count_result_t count_matches(logic [VAL_W-1:0] key);
    count_result_t res;
    int n;
    int lo_pos;
    int hi_pos;
    int occ;
    res = '0;
    n = (entry_count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_mirror);
    lo_pos = find_edge(n, key, 1'b0);
    hi_pos = find_edge(n, key, 1'b1);
    if (lo_pos != -1 && hi_pos != -1 && hi_pos >= lo_pos) begin
      occ = hi_pos - lo_pos + 1;
      res.occ = (occ > 2047) ? 11'd2047 : occ[OCC_W-1:0];
      res.pos = lo_pos[POS_W-1:0];
      res.found = 1'b1;
    end
    return res;
  endfunction

  function automatic stim_row_t mk_row(bit is_cfg, stoc_op_t op, int idx, logic [VAL_W-1:0] value,
                                       bit typed, int occ, int pos, bit fnd);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.op = op;
    r.idx = idx[IDX_W-1:0];
    r.value = value;
    r.typed = typed;
    r.fixed.occ = occ[OCC_W-1:0];
    r.fixed.pos = pos[POS_W-1:0];
    r.fixed.found = fnd;
    return r;
  endfunction

  // Present one item, bursting or gapping first, and predict at its transfer.
  task automatic send_item(stoc_op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value,
                           bit typed, count_result_t fixed);
    int gap;
    count_result_t expect_res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, value, idx};
    do @(posedge clk); while (!in_tready);
    item_count++;
    if (op == OP_WRITE) begin
      table_mirror[idx] = value;
      write_count++;
    end else begin
      expect_res = typed ? fixed : count_matches(value);
      pending_counts.push_back(expect_res);
      if (expect_res.found) hit_count++;
      query_count++;
    end
  endtask

  // Write entry_count only once the block has drained.
  task automatic program_entry_count(logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    entry_count_mirror = value;
    cfg_count++;
  endtask

  // Search the whole depth: write only the positions that the searches for the
  // smallest key, zero and the largest key visit, then query those keys with
  // entry_count at the depth and past it.
  task automatic probe_full_depth();
    int p;
    p = TABLE_DEPTH / 2 - 1;
    while (p > 0) begin
      send_item(OP_WRITE, p[IDX_W-1:0], VAL_W'(p), 1'b0, '0);
      p = (p + 1) / 2 - 1;
    end
    send_item(OP_WRITE, '0, VAL_MIN, 1'b0, '0);
    p = TABLE_DEPTH / 2 - 1 + TABLE_DEPTH / 4;
    while (p < TABLE_DEPTH - 1) begin
      send_item(OP_WRITE, p[IDX_W-1:0], VAL_W'(p), 1'b0, '0);
      p = p + (TABLE_DEPTH - p) / 2;
    end
    send_item(OP_WRITE, IDX_W'(TABLE_DEPTH - 1), VAL_MAX, 1'b0, '0);
    program_entry_count(CFG_W'(TABLE_DEPTH));
    send_item(OP_QUERY, '0, VAL_MIN, 1'b0, '0);
    send_item(OP_QUERY, '0, VAL_MAX, 1'b0, '0);
    send_item(OP_QUERY, '0, 32'd0, 1'b0, '0);
    program_entry_count(CFG_W'(2047));
    send_item(OP_QUERY, '0, VAL_MAX, 1'b0, '0);
    send_item(OP_QUERY, '0, VAL_MIN, 1'b0, '0);
    send_item(OP_QUERY, '0, 32'd0, 1'b0, '0);
  endtask

  // Fill positions 0..m-1 with an ascending run that repeats values often.
  task automatic load_sorted_run(int m);
    longint cur;
    int step_max;
    int mode;
    mode = $urandom_range(0, 2);
    case (mode)
      0:       cur = -64'sd2147483648;
      1:       cur = longint'($signed($urandom));
      default: cur = longint'($urandom_range(0, 40)) - 20;
    endcase
    case ($urandom_range(0, 2))
      0:       step_max = 1;
      1:       step_max = 50;
      default: step_max = 1 << 24;
    endcase
    for (int i = 0; i < m; i++) begin
      if (i > 0 && $urandom_range(0, 9) >= 4) cur += $urandom_range(1, step_max);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      send_item(OP_WRITE, i[IDX_W-1:0], cur[VAL_W-1:0], 1'b0, '0);
    end
  endtask

  // Receiver: runs of ready and of stall, some short, some long.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin ready_level = 1'b1; ready_run = $urandom_range(1, 20); end
          5, 6, 7:       begin ready_level = 1'b0; ready_run = $urandom_range(1, 4); end
          8:             begin ready_level = 1'b0; ready_run = $urandom_range(5, 24); end
          default:       begin ready_level = 1'b1; ready_run = $urandom_range(50, 200); end
        endcase
      end
      ready_run--;
      out_tready <= ready_level;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: result with nothing expected: occ=%0d pos=%0d found=%0b",
                 $time, out_tdata[OCC_W-1:0], out_tdata[OCC_W +: POS_W], out_tuser);
        mismatch_count++;
      end else begin
        got_result = pending_counts.pop_front();
        if (out_tdata[OCC_W-1:0] !== got_result.occ) begin
          $display("%0t: occurrences expected %0d actual %0d",
                   $time, got_result.occ, out_tdata[OCC_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OCC_W +: POS_W] !== got_result.pos) begin
          $display("%0t: first_position expected %0d actual %0d",
                   $time, got_result.pos, out_tdata[OCC_W +: POS_W]);
          mismatch_count++;
        end
        if (out_tuser !== got_result.found) begin
          $display("%0t: found expected %0b actual %0b", $time, got_result.found, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_counts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n;
    int m;
    int phase;
    int phase_items;
    int pick;
    int idx;
    logic [VAL_W-1:0] key;

    // Directed rows: empty table after reset, extremes of the value range,
    // runs of equal keys, absent keys, a count of one, an empty count, a
    // write at the top index and a table knocked out of order.
    directed_rows = '{
      mk_row(0, OP_QUERY, 0,    32'd0,        1, 0, 0, 0),
      mk_row(0, OP_QUERY, 1023, VAL_MIN,      1, 0, 0, 0),
      mk_row(0, OP_WRITE, 0,    VAL_MIN,      0, 0, 0, 0),
      mk_row(0, OP_WRITE, 1,    -32'sd5,      0, 0, 0, 0),
      mk_row(0, OP_WRITE, 2,    -32'sd5,      0, 0, 0, 0),
      mk_row(0, OP_WRITE, 3,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_WRITE, 4,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_WRITE, 5,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_WRITE, 6,    VAL_MAX,      0, 0, 0, 0),
      mk_row(1, OP_WRITE, 0,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    VAL_MIN,      1, 1, 0, 1),
      mk_row(0, OP_QUERY, 0,    VAL_MAX,      1, 1, 6, 1),
      mk_row(0, OP_QUERY, 0,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    -32'sd5,      0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    32'd0,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    32'd8,        0, 0, 0, 0),
      mk_row(1, OP_WRITE, 0,    32'd1,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    VAL_MIN,      0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    -32'sd5,      0, 0, 0, 0),
      mk_row(1, OP_WRITE, 0,    32'd0,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    32'd7,        1, 0, 0, 0),
      mk_row(0, OP_WRITE, 1023, 32'h2aaa_aaaa, 0, 0, 0, 0),
      mk_row(0, OP_WRITE, 3,    VAL_MAX,      0, 0, 0, 0),
      mk_row(1, OP_WRITE, 0,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    32'd7,        0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    VAL_MAX,      0, 0, 0, 0),
      mk_row(0, OP_QUERY, 0,    -32'sd5,      0, 0, 0, 0)
    };

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        program_entry_count(directed_rows[i].value[CFG_W-1:0]);
      else
        send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].fixed);
    end

    probe_full_depth();

    // Random phases: each writes a sorted prefix that covers the searched
    // range, sets entry_count, then mixes queries with writes.
    phase = 0;
    while (item_count < ITEM_BUDGET) begin
      case (phase)
        6:       n = 0;
        7:       n = 1;
        8:       n = 2;
        default: n = $urandom_range(1, 48);
      endcase
      m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      load_sorted_run(m);
      program_entry_count(n[CFG_W-1:0]);

      phase_items = $urandom_range(20, 50);
      repeat (phase_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // Mostly keys that sit in the table, some neighbors, some noise.
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: key = (m > 0) ? table_mirror[$urandom_range(0, m - 1)] : $urandom;
            6, 7: begin
              key = (m > 0) ? table_mirror[$urandom_range(0, m - 1)] : $urandom;
              key = $urandom_range(0, 1) ? key + 1 : key - 1;
            end
            8:       key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: key = $urandom;
          endcase
          send_item(OP_QUERY, IDX_W'($urandom_range(0, 1023)), key, 1'b0, '0);
        end else if (pick < 85 && m > 1) begin
          // Copy a neighbor into a slot: order holds, runs grow.
          idx = $urandom_range(0, m - 1);
          key = (idx == 0) ? table_mirror[1] : table_mirror[idx - 1];
          send_item(OP_WRITE, idx[IDX_W-1:0], key, 1'b0, '0);
        end else begin
          send_item(OP_WRITE, IDX_W'($urandom_range(0, 1023)), $urandom, 1'b0, '0);
        end

        // Now and then drain completely before the next item.
        if ($urandom_range(0, 39) == 0) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_counts.size() != 0);
        end
      end
      phase++;
    end

    // Drain, then wait out SETTLE_CYCLES for any stray result.
    in_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d table writes and %0d queries (%0d with the key present)",
             write_count, query_count, hit_count);
    $display("over %0d entry_count settings from 0 through 2047; %0d mismatches",
             cfg_count, mismatch_count);
    if (mismatch_count == 0 && pending_counts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sorted_table_occurrence_count_core.f =====
hw/rtl/stoc_pkg.sv
hw/rtl/stoc_ctrl.sv
hw/rtl/stoc_dpath.sv
hw/rtl/sorted_table_occurrence_count_core.sv
hw/rtl/stoc_checker.sv
tb/sv/sorted_table_occurrence_count_core_tb.sv
